// ===== rtl/core/mpsm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers of the multi-pattern string matcher.
package mpsm_pkg;

   // Default sizes of the trie
   localparam int MAX_VERTICES_DEF            = 64;
   localparam int MAX_EDGES_PER_VERTEX_DEF    = 8;
   localparam int MAX_PATTERNS_DEF            = 16;
   localparam int MAX_PATTERNS_PER_VERTEX_DEF = 4;

   // Command codes
   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_PATTERN = 2'd1;
   localparam logic [1:0] CMD_BUILD   = 2'd2;
   localparam logic [1:0] CMD_TEXT    = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_MATCH  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   // Symbol code of a byte that is no letter
   localparam logic [4:0] NO_LETTER = 5'd26;

   // Most match beats one text character may give
   localparam int RESULT_LIMIT = 16;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
      logic       first;
      logic       last;
      logic [7:0] pattern_length;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  pattern_index;
      logic [15:0] text_position;
      logic        last_res;
   } rsp_item_type;

   // Classified item handed from the front to the engine
   typedef struct packed {
      logic [1:0] command;
      logic [4:0] symbol;
      logic       first;
      logic       last;
      logic [7:0] pattern_length;
   } job_type;

   // Fold upper and lower case onto one symbol 0..25
   function automatic logic [4:0] letter_of(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd0;
         if (c inside {[8'h41:8'h5A]}) begin
            d = c - 8'h41;
         end else if (c inside {[8'h61:8'h7A]}) begin
            d = c - 8'h61;
         end else begin
            d = {3'd0, NO_LETTER};
         end
         return d[4:0];
      end
   endfunction

endpackage

// ===== rtl/core/mpsm_front.sv =====
`timescale 1ns / 1ps
// Front end: takes request beats, classifies the character and queues jobs.
module mpsm_front
   import mpsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         job_valid,
   input  logic         job_pop,
   output job_type      job
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;
   job_type    classified;

   // Classify the incoming beat
   always_comb begin
      classified.command        = req_item.command;
      classified.symbol         = letter_of(req_item.char_code);
      classified.first          = req_item.first;
      classified.last           = req_item.last;
      classified.pattern_length = req_item.pattern_length;
   end

   assign req_stall = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job       = slot_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = job_pop && job_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the queued payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== rtl/core/mpsm_engine.sv =====
`timescale 1ns / 1ps
// Back end: trie memories, load, link build and text walk sequencer.
module mpsm_engine
   import mpsm_pkg::*;
#(
   parameter int MAX_VERTICES            = MAX_VERTICES_DEF,
   parameter int MAX_EDGES_PER_VERTEX    = MAX_EDGES_PER_VERTEX_DEF,
   parameter int MAX_PATTERNS            = MAX_PATTERNS_DEF,
   parameter int MAX_PATTERNS_PER_VERTEX = MAX_PATTERNS_PER_VERTEX_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   output logic         job_pop,
   input  job_type      job,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int CW     = $clog2(MAX_VERTICES + 1);
   localparam int EDEPTH = MAX_VERTICES * MAX_EDGES_PER_VERTEX;
   localparam int EAW    = $clog2(EDEPTH);
   localparam int ECW    = $clog2(MAX_EDGES_PER_VERTEX + 1);
   localparam int PDEPTH = MAX_VERTICES * MAX_PATTERNS_PER_VERTEX;
   localparam int PAW    = $clog2(PDEPTH);
   localparam int PCW    = $clog2(MAX_PATTERNS_PER_VERTEX + 1);
   localparam int LPW    = $clog2(MAX_PATTERNS + 1);
   localparam int PIW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int RLW    = $clog2(RESULT_LIMIT + 1);

   // Sequencer states
   localparam logic [4:0] ST_INIT     = 5'd0;
   localparam logic [4:0] ST_IDLE     = 5'd1;
   localparam logic [4:0] ST_LK_CNT   = 5'd2;
   localparam logic [4:0] ST_LK_N     = 5'd3;
   localparam logic [4:0] ST_LK_RD    = 5'd4;
   localparam logic [4:0] ST_LK_CMP   = 5'd5;
   localparam logic [4:0] ST_ADV_FAIL = 5'd6;
   localparam logic [4:0] ST_ADV_DONE = 5'd7;
   localparam logic [4:0] ST_L_ALLOC  = 5'd8;
   localparam logic [4:0] ST_L_LINK   = 5'd9;
   localparam logic [4:0] ST_P_END    = 5'd10;
   localparam logic [4:0] ST_P_ACC    = 5'd11;
   localparam logic [4:0] ST_B_CNT    = 5'd12;
   localparam logic [4:0] ST_B_N      = 5'd13;
   localparam logic [4:0] ST_B_EDGE   = 5'd14;
   localparam logic [4:0] ST_B_EC     = 5'd15;
   localparam logic [4:0] ST_B_POP    = 5'd16;
   localparam logic [4:0] ST_B_V      = 5'd17;
   localparam logic [4:0] ST_B_F      = 5'd18;
   localparam logic [4:0] ST_B_FV     = 5'd19;
   localparam logic [4:0] ST_CH_START = 5'd20;
   localparam logic [4:0] ST_CH_CNT   = 5'd21;
   localparam logic [4:0] ST_CH_PAT   = 5'd22;
   localparam logic [4:0] ST_CH_EMIT  = 5'd23;
   localparam logic [4:0] ST_CH_NEXT  = 5'd24;
   localparam logic [4:0] ST_TEXT_END = 5'd25;
   localparam logic [4:0] ST_FLUSH    = 5'd26;

   // Lookup modes and walk return targets
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_ADV  = 1'b1;
   localparam logic RET_TEXT  = 1'b0;
   localparam logic RET_BUILD = 1'b1;

   // Trie memories
   logic [ECW-1:0] ecnt_mem [MAX_VERTICES];
   logic [VW-1:0]  fail_mem [MAX_VERTICES];
   logic [PCW-1:0] vpc_mem  [MAX_VERTICES];
   logic [4:0]     esym_mem [EDEPTH];
   logic [VW-1:0]  etgt_mem [EDEPTH];
   logic [PIW-1:0] vpat_mem [PDEPTH];
   logic [VW-1:0]  bfsq_mem [MAX_VERTICES];

   // Registered read data
   logic [ECW-1:0] ecnt_rd_ff;
   logic [VW-1:0]  fail_rd_ff;
   logic [PCW-1:0] vpc_rd_ff;
   logic [4:0]     esym_rd_ff;
   logic [VW-1:0]  etgt_rd_ff;
   logic [PIW-1:0] vpat_rd_ff;
   logic [VW-1:0]  bfsq_rd_ff;

   // Read addresses
   logic [VW-1:0]  ecnt_ra;
   logic [VW-1:0]  fail_ra;
   logic [VW-1:0]  vpc_ra;
   logic [EAW-1:0] edge_ra;
   logic [PAW-1:0] vpat_ra;

   // Write ports
   logic           ecnt_we;
   logic [VW-1:0]  ecnt_wa;
   logic [ECW-1:0] ecnt_wd;
   logic           fail_we;
   logic [VW-1:0]  fail_wa;
   logic [VW-1:0]  fail_wd;
   logic           vpc_we;
   logic [VW-1:0]  vpc_wa;
   logic [PCW-1:0] vpc_wd;
   logic           edge_we;
   logic [EAW-1:0] edge_wa;
   logic           vpat_we;
   logic [PAW-1:0] vpat_wa;
   logic           bfsq_we;
   logic [VW-1:0]  bfsq_wd;

   // Sequencer and trie registers
   logic [4:0]     state_ff,    state_in;
   job_type        job_ff,      job_in;
   logic [CW-1:0]  used_ff,     used_in;
   logic [LPW-1:0] loaded_ff,   loaded_in;
   logic [VW-1:0]  load_v_ff,   load_v_in;
   logic           load_rej_ff, load_rej_in;
   logic [VW-1:0]  match_v_ff,  match_v_in;
   logic [15:0]    text_cnt_ff, text_cnt_in;
   logic [VW-1:0]  cur_v_ff,    cur_v_in;
   logic [4:0]     lk_sym_ff,   lk_sym_in;
   logic           lk_mode_ff,  lk_mode_in;
   logic           adv_ret_ff,  adv_ret_in;
   logic [VW-1:0]  adv_res_ff,  adv_res_in;
   logic [ECW-1:0] ecnt_ff,     ecnt_in;
   logic [ECW-1:0] idx_ff,      idx_in;
   logic [ECW-1:0] bcnt_ff,     bcnt_in;
   logic [ECW-1:0] bidx_ff,     bidx_in;
   logic [VW-1:0]  new_v_ff,    new_v_in;
   logic [CW-1:0]  head_ff,     head_in;
   logic [CW-1:0]  tail_ff,     tail_in;
   logic [VW-1:0]  bv_ff,       bv_in;
   logic [VW-1:0]  fv_ff,       fv_in;
   logic [VW-1:0]  child_ff,    child_in;
   logic           root_ph_ff,  root_ph_in;
   logic [VW-1:0]  ch_v_ff,     ch_v_in;
   logic [PCW-1:0] pcnt_ff,     pcnt_in;
   logic [PCW-1:0] pi_ff,       pi_in;
   logic [RLW-1:0] nres_ff,     nres_in;
   logic           pend_v_ff,   pend_v_in;
   rsp_item_type   pend_ff,     pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_ff,      rsp_in;

   logic           out_free;
   logic [8:0]     len_sum;
   logic [VW-1:0]  start_v;
   logic           start_rej;
   logic [15:0]    cnt_base;

   function automatic logic [EAW-1:0] edge_addr(input logic [VW-1:0] v,
                                                input logic [ECW-1:0] i);
      return EAW'(EAW'(v) * EAW'(MAX_EDGES_PER_VERTEX) + EAW'(i));
   endfunction

   function automatic logic [PAW-1:0] pat_addr(input logic [VW-1:0] v,
                                               input logic [PCW-1:0] i);
      return PAW'(PAW'(v) * PAW'(MAX_PATTERNS_PER_VERTEX) + PAW'(i));
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign job_pop   = (state_ff == ST_IDLE);

   // Pattern start check
   assign len_sum   = 9'(used_ff) + 9'(job.pattern_length);
   assign start_v   = job.first ? VW'(0) : load_v_ff;
   assign start_rej = job.first ? ((loaded_ff >= LPW'(MAX_PATTERNS)) ||
                                   (job.pattern_length == 8'd0) ||
                                   (len_sum > 9'(MAX_VERTICES)))
                                : load_rej_ff;
   assign cnt_base  = job.first ? 16'd0 : text_cnt_ff;

   // Pick read addresses
   always_comb begin
      ecnt_ra = cur_v_ff;
      fail_ra = ch_v_ff;
      vpc_ra  = ch_v_ff;
      edge_ra = edge_addr(cur_v_ff, idx_ff);
      vpat_ra = pat_addr(ch_v_ff, pi_ff);
      case (state_ff)
         ST_B_CNT:  ecnt_ra = bv_ff;
         ST_B_EDGE: edge_ra = edge_addr(bv_ff, bidx_ff);
         ST_LK_RD:  fail_ra = cur_v_ff;
         ST_B_F:    fail_ra = bv_ff;
         ST_P_END:  vpc_ra  = load_v_ff;
         default: begin
            ecnt_ra = cur_v_ff;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      used_in      = used_ff;
      loaded_in    = loaded_ff;
      load_v_in    = load_v_ff;
      load_rej_in  = load_rej_ff;
      match_v_in   = match_v_ff;
      text_cnt_in  = text_cnt_ff;
      cur_v_in     = cur_v_ff;
      lk_sym_in    = lk_sym_ff;
      lk_mode_in   = lk_mode_ff;
      adv_ret_in   = adv_ret_ff;
      adv_res_in   = adv_res_ff;
      ecnt_in      = ecnt_ff;
      idx_in       = idx_ff;
      bcnt_in      = bcnt_ff;
      bidx_in      = bidx_ff;
      new_v_in     = new_v_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      bv_in        = bv_ff;
      fv_in        = fv_ff;
      child_in     = child_ff;
      root_ph_in   = root_ph_ff;
      ch_v_in      = ch_v_ff;
      pcnt_in      = pcnt_ff;
      pi_in        = pi_ff;
      nres_in      = nres_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ecnt_we      = 1'b0;
      ecnt_wa      = cur_v_ff;
      ecnt_wd      = '0;
      fail_we      = 1'b0;
      fail_wa      = child_ff;
      fail_wd      = adv_res_ff;
      vpc_we       = 1'b0;
      vpc_wa       = load_v_ff;
      vpc_wd       = '0;
      edge_we      = 1'b0;
      edge_wa      = edge_addr(cur_v_ff, ecnt_ff);
      vpat_we      = 1'b0;
      vpat_wa      = pat_addr(load_v_ff, vpc_rd_ff);
      bfsq_we      = 1'b0;
      bfsq_wd      = child_ff;

      case (state_ff)
         // Reset the root and the scalar state
         ST_INIT: begin
            ecnt_we     = 1'b1;
            ecnt_wa     = VW'(0);
            fail_we     = 1'b1;
            fail_wa     = VW'(0);
            fail_wd     = VW'(0);
            vpc_we      = 1'b1;
            vpc_wa      = VW'(0);
            used_in     = CW'(1);
            loaded_in   = '0;
            load_v_in   = '0;
            load_rej_in = 1'b0;
            match_v_in  = '0;
            text_cnt_in = 16'd0;
            state_in    = ST_IDLE;
         end

         // Take the next job and dispatch it
         ST_IDLE: begin
            if (job_valid) begin
               job_in = job;
               case (job.command)
                  CMD_CLEAR: begin
                     state_in = ST_INIT;
                  end
                  CMD_PATTERN: begin
                     load_v_in   = start_v;
                     load_rej_in = start_rej;
                     if (!start_rej && job.symbol != NO_LETTER) begin
                        cur_v_in   = start_v;
                        lk_sym_in  = job.symbol;
                        lk_mode_in = MODE_LOAD;
                        state_in   = ST_LK_CNT;
                     end else begin
                        state_in = ST_P_END;
                     end
                  end
                  CMD_BUILD: begin
                     if (used_ff <= CW'(1)) begin
                        pend_in   = '{KIND_DONE, 4'd0, 16'd0, 1'b0};
                        pend_v_in = 1'b1;
                        state_in  = ST_FLUSH;
                     end else begin
                        head_in    = '0;
                        tail_in    = '0;
                        bv_in      = '0;
                        root_ph_in = 1'b1;
                        state_in   = ST_B_CNT;
                     end
                  end
                  default: begin
                     text_cnt_in = cnt_base;
                     if (job.symbol == NO_LETTER) begin
                        match_v_in  = '0;
                        text_cnt_in = (cnt_base != 16'hFFFF) ? cnt_base + 16'd1 : cnt_base;
                     end else begin
                        cur_v_in   = job.first ? VW'(0) : match_v_ff;
                        lk_sym_in  = job.symbol;
                        lk_mode_in = MODE_ADV;
                        adv_ret_in = RET_TEXT;
                        state_in   = ST_LK_CNT;
                     end
                  end
               endcase
            end
         end

         // Edge lookup: fetch the edge count
         ST_LK_CNT: begin
            state_in = ST_LK_N;
         end

         ST_LK_N: begin
            ecnt_in  = (ecnt_rd_ff > ECW'(MAX_EDGES_PER_VERTEX)) ?
                       ECW'(MAX_EDGES_PER_VERTEX) : ecnt_rd_ff;
            idx_in   = '0;
            state_in = ST_LK_RD;
         end

         // Edge lookup: read one edge or give up
         ST_LK_RD: begin
            if (idx_ff < ecnt_ff) begin
               state_in = ST_LK_CMP;
            end else if (lk_mode_ff == MODE_LOAD) begin
               state_in = ST_L_ALLOC;
            end else if (cur_v_ff == VW'(0)) begin
               adv_res_in = '0;
               state_in   = ST_ADV_DONE;
            end else begin
               state_in = ST_ADV_FAIL;
            end
         end

         ST_LK_CMP: begin
            if (esym_rd_ff == lk_sym_ff) begin
               if (lk_mode_ff == MODE_LOAD) begin
                  load_v_in = etgt_rd_ff;
                  state_in  = ST_P_END;
               end else begin
                  adv_res_in = etgt_rd_ff;
                  state_in   = ST_ADV_DONE;
               end
            end else begin
               idx_in   = idx_ff + ECW'(1);
               state_in = ST_LK_RD;
            end
         end

         // Follow the failure link and retry
         ST_ADV_FAIL: begin
            cur_v_in = fail_rd_ff;
            state_in = ST_LK_CNT;
         end

         ST_ADV_DONE: begin
            if (adv_ret_ff == RET_TEXT) begin
               match_v_in = adv_res_ff;
               ch_v_in    = adv_res_ff;
               nres_in    = '0;
               state_in   = ST_CH_START;
            end else begin
               fail_we  = 1'b1;
               bfsq_we  = 1'b1;
               tail_in  = tail_ff + CW'(1);
               bidx_in  = bidx_ff + ECW'(1);
               state_in = ST_B_EDGE;
            end
         end

         // Allocate a new vertex
         ST_L_ALLOC: begin
            if (used_ff >= CW'(MAX_VERTICES)) begin
               load_rej_in = 1'b1;
               state_in    = ST_P_END;
            end else begin
               ecnt_we  = 1'b1;
               ecnt_wa  = VW'(used_ff);
               fail_we  = 1'b1;
               fail_wa  = VW'(used_ff);
               fail_wd  = '0;
               vpc_we   = 1'b1;
               vpc_wa   = VW'(used_ff);
               new_v_in = VW'(used_ff);
               used_in  = used_ff + CW'(1);
               if (ecnt_ff >= ECW'(MAX_EDGES_PER_VERTEX)) begin
                  load_rej_in = 1'b1;
                  state_in    = ST_P_END;
               end else begin
                  state_in = ST_L_LINK;
               end
            end
         end

         // Hang the new vertex under the load vertex
         ST_L_LINK: begin
            edge_we   = 1'b1;
            ecnt_we   = 1'b1;
            ecnt_wa   = cur_v_ff;
            ecnt_wd   = ecnt_ff + ECW'(1);
            load_v_in = new_v_ff;
            state_in  = ST_P_END;
         end

         ST_P_END: begin
            state_in = job_ff.last ? ST_P_ACC : ST_IDLE;
         end

         // Accept or reject the finished pattern
         ST_P_ACC: begin
            if (!load_rej_ff && loaded_ff < LPW'(MAX_PATTERNS) &&
                vpc_rd_ff < PCW'(MAX_PATTERNS_PER_VERTEX)) begin
               vpat_we   = 1'b1;
               vpc_we    = 1'b1;
               vpc_wd    = vpc_rd_ff + PCW'(1);
               pend_in   = '{KIND_ACCEPT, 4'(loaded_ff), 16'd0, 1'b0};
               loaded_in = loaded_ff + LPW'(1);
            end else begin
               pend_in = '{KIND_REJECT, 4'd0, 16'd0, 1'b0};
            end
            pend_v_in   = 1'b1;
            load_v_in   = '0;
            load_rej_in = 1'b0;
            state_in    = ST_FLUSH;
         end

         // Link build: edge count of the current vertex
         ST_B_CNT: begin
            state_in = ST_B_N;
         end

         ST_B_N: begin
            bcnt_in  = (ecnt_rd_ff > ECW'(MAX_EDGES_PER_VERTEX)) ?
                       ECW'(MAX_EDGES_PER_VERTEX) : ecnt_rd_ff;
            bidx_in  = '0;
            state_in = ST_B_EDGE;
         end

         ST_B_EDGE: begin
            state_in = (bidx_ff < bcnt_ff) ? ST_B_EC : ST_B_POP;
         end

         // Enqueue a child and set its link
         ST_B_EC: begin
            child_in = etgt_rd_ff;
            if (tail_ff >= CW'(MAX_VERTICES)) begin
               bidx_in  = bidx_ff + ECW'(1);
               state_in = ST_B_EDGE;
            end else if (root_ph_ff) begin
               fail_we  = 1'b1;
               fail_wa  = etgt_rd_ff;
               fail_wd  = '0;
               bfsq_we  = 1'b1;
               bfsq_wd  = etgt_rd_ff;
               tail_in  = tail_ff + CW'(1);
               bidx_in  = bidx_ff + ECW'(1);
               state_in = ST_B_EDGE;
            end else begin
               cur_v_in   = fv_ff;
               lk_sym_in  = esym_rd_ff;
               lk_mode_in = MODE_ADV;
               adv_ret_in = RET_BUILD;
               state_in   = ST_LK_CNT;
            end
         end

         // Take the next vertex off the queue
         ST_B_POP: begin
            root_ph_in = 1'b0;
            if (head_ff < tail_ff) begin
               state_in = ST_B_V;
            end else begin
               pend_in   = '{KIND_DONE, 4'd0, 16'd0, 1'b0};
               pend_v_in = 1'b1;
               state_in  = ST_FLUSH;
            end
         end

         ST_B_V: begin
            bv_in    = bfsq_rd_ff;
            head_in  = head_ff + CW'(1);
            state_in = ST_B_F;
         end

         ST_B_F: begin
            state_in = ST_B_FV;
         end

         ST_B_FV: begin
            fv_in    = fail_rd_ff;
            state_in = ST_B_CNT;
         end

         // Output chain: stop at the root
         ST_CH_START: begin
            state_in = (ch_v_ff == VW'(0)) ? ST_TEXT_END : ST_CH_CNT;
         end

         ST_CH_CNT: begin
            pcnt_in  = (vpc_rd_ff > PCW'(MAX_PATTERNS_PER_VERTEX)) ?
                       PCW'(MAX_PATTERNS_PER_VERTEX) : vpc_rd_ff;
            pi_in    = '0;
            state_in = ST_CH_PAT;
         end

         ST_CH_PAT: begin
            if (pi_ff < pcnt_ff && nres_ff < RLW'(RESULT_LIMIT)) begin
               state_in = ST_CH_EMIT;
            end else begin
               state_in = ST_CH_NEXT;
            end
         end

         // Hand on the held beat and hold the new match
         ST_CH_EMIT: begin
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
               pend_in   = '{KIND_MATCH, 4'(vpat_rd_ff), text_cnt_ff, 1'b0};
               pend_v_in = 1'b1;
               pi_in     = pi_ff + PCW'(1);
               nres_in   = nres_ff + RLW'(1);
               state_in  = ST_CH_PAT;
            end
         end

         ST_CH_NEXT: begin
            ch_v_in  = fail_rd_ff;
            state_in = ST_CH_START;
         end

         ST_TEXT_END: begin
            if (text_cnt_ff != 16'hFFFF) begin
               text_cnt_in = text_cnt_ff + 16'd1;
            end
            state_in = ST_FLUSH;
         end

         // Drain the held beat, marked as last
         ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               rsp_in.last_res = 1'b1;
               pend_v_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      used_ff     <= used_in;
      loaded_ff   <= loaded_in;
      load_v_ff   <= load_v_in;
      load_rej_ff <= load_rej_in;
      match_v_ff  <= match_v_in;
      text_cnt_ff <= text_cnt_in;
      cur_v_ff    <= cur_v_in;
      lk_sym_ff   <= lk_sym_in;
      lk_mode_ff  <= lk_mode_in;
      adv_ret_ff  <= adv_ret_in;
      adv_res_ff  <= adv_res_in;
      ecnt_ff     <= ecnt_in;
      idx_ff      <= idx_in;
      bcnt_ff     <= bcnt_in;
      bidx_ff     <= bidx_in;
      new_v_ff    <= new_v_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      bv_ff       <= bv_in;
      fv_ff       <= fv_in;
      child_ff    <= child_in;
      root_ph_ff  <= root_ph_in;
      ch_v_ff     <= ch_v_in;
      pcnt_ff     <= pcnt_in;
      pi_ff       <= pi_in;
      nres_ff     <= nres_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   // Per-vertex memories
   always_ff @(posedge clock) begin
      if (ecnt_we) begin
         ecnt_mem[ecnt_wa] <= ecnt_wd;
      end
      if (fail_we) begin
         fail_mem[fail_wa] <= fail_wd;
      end
      if (vpc_we) begin
         vpc_mem[vpc_wa] <= vpc_wd;
      end
      if (bfsq_we) begin
         bfsq_mem[VW'(tail_ff)] <= bfsq_wd;
      end
      ecnt_rd_ff <= ecnt_mem[ecnt_ra];
      fail_rd_ff <= fail_mem[fail_ra];
      vpc_rd_ff  <= vpc_mem[vpc_ra];
      bfsq_rd_ff <= bfsq_mem[VW'(head_ff)];
   end

   // Edge and pattern list memories
   always_ff @(posedge clock) begin
      if (edge_we) begin
         esym_mem[edge_wa] <= lk_sym_ff;
         etgt_mem[edge_wa] <= new_v_ff;
      end
      if (vpat_we) begin
         vpat_mem[vpat_wa] <= PIW'(loaded_ff);
      end
      esym_rd_ff <= esym_mem[edge_ra];
      etgt_rd_ff <= etgt_mem[edge_ra];
      vpat_rd_ff <= vpat_mem[vpat_ra];
   end

endmodule

// ===== rtl/core/multi_pattern_string_matcher_unit.sv =====
`timescale 1ns / 1ps
// Multi-pattern matcher top: two-entry request queue, trie engine, registered result.
// One item at a time; a pattern character takes longer per scanned edge; a build of
// an empty trie goes straight to its done beat, else takes longer per non-root vertex,
// root edge, other edge, link step and scanned edge; a text character is quickest for
// a non-letter, else takes longer per scanned edge, link step, chain vertex and match
// beat. Result stalls hold the engine; synchronous reset and clear set up the root.
module multi_pattern_string_matcher_unit
   import mpsm_pkg::*;
#(
   parameter int MAX_VERTICES            = MAX_VERTICES_DEF,
   parameter int MAX_EDGES_PER_VERTEX    = MAX_EDGES_PER_VERTEX_DEF,
   parameter int MAX_PATTERNS            = MAX_PATTERNS_DEF,
   parameter int MAX_PATTERNS_PER_VERTEX = MAX_PATTERNS_PER_VERTEX_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic    job_valid;
   logic    job_pop;
   job_type job;

   // Accept and classify
   mpsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job)
   );

   // Carry out
   mpsm_engine #(
      .MAX_VERTICES            (MAX_VERTICES),
      .MAX_EDGES_PER_VERTEX    (MAX_EDGES_PER_VERTEX),
      .MAX_PATTERNS            (MAX_PATTERNS),
      .MAX_PATTERNS_PER_VERTEX (MAX_PATTERNS_PER_VERTEX)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // An accepted beat leaves the queue non-empty
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> job_valid)
      else $error("queue empty after accepted request beat");

   // A queue full of jobs must stall the request side
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (job_valid && !job_pop && req_valid && !req_stall) |=> req_stall || job_pop)
      else $error("queue overrun");

   // Reset leaves no result beat
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

endmodule
